FILE: design/uart_8n1_transceiver_echo_unit_defines.svh
// Assertion macros shared by the checker of the UART echo unit.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef UART_8N1_TRANSCEIVER_ECHO_UNIT_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_ECHO_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UECHO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UECHO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/uecho_pkg.sv
// Types and constants of the UART echo unit.
// Used by the queue, the core, the top level and the checker.
package uecho_pkg;

    localparam int unsigned TICK_W      = 16;
    localparam int unsigned RX_TIMER_W  = 17;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd1667;
    localparam logic [BYTE_W-1:0] ECHO_ON_CODE    = 8'h05;
    localparam logic [BYTE_W-1:0] ECHO_OFF_CODE   = 8'h06;
    // register index as seen on paddr[2]
    localparam logic              REG_BIT_TICKS   = 1'b0;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [BYTE_W-1:0] tx_data;
        logic              tx_valid;
        logic              rx_level;
    } t_in_item;

    typedef struct packed {
        logic              echo_on;
        logic [BYTE_W-1:0] rx_data;
        logic              rx_valid;
        logic              tx_ready;
        logic              tx_level;
    } t_out_item;

    typedef enum logic [1:0] {
        RX_HUNT = 2'd0,
        RX_DATA = 2'd1,
        RX_STOP = 2'd2
    } t_rx_phase;

endpackage

FILE: design/uart_8n1_transceiver_echo_unit.sv
// Top level of the UART 8N1 transceiver with echo mode.
// Depends on uecho_pkg, uecho_queue and uecho_core.
//
// Every input transfer is one clock tick of the UART: s_axis_tdata carries the
// sampled receive line and an optional byte to send. Every tick yields exactly
// one output transfer on m_axis with the transmit line level, the transmitter
// ready flag, a received byte with its valid flag and the echo mode flag.
// The bit period in ticks is set through the APB register bit_ticks at
// address 0 (reset 1667); write it only while no tick is in flight.
// Throughput: one tick per cycle while m_axis_tready is high. The core executes
// one tick per cycle when its output register is free, and the tick-to-tick
// state update is a single registered step. An input transfer is written into
// the two-entry input queue, then executed by the core into its output register.
// At reset the transmit line is idle high, the receiver hunts for a start bit,
// echo is off and both queue and output register are empty.
// When the output side stalls, the output register holds its result, the
// queue fills, and s_axis_tready drops after at most two more ticks; no tick
// is lost.
module uart_8n1_transceiver_echo_unit import uecho_pkg::*; #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // rx_level[0], tx_valid[1], tx_data[9:2], upper bits zero
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tx_level[0], tx_ready[1], rx_valid[2], rx_data[10:3], echo_on[11], upper bits zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [TICK_W-1:0] r_bit_ticks;
    logic              w_reg_sel;
    t_in_item          w_in_item;
    t_in_item          w_q_item;
    logic              w_q_valid;
    logic              w_q_ready;
    t_out_item         w_out_item;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_BIT_TICKS);
    assign prdata    = w_reg_sel ? APB_DATA_W'(r_bit_ticks) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks <= BIT_TICKS_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_bit_ticks <= pwdata[TICK_W-1:0];
        end
    end

    assign w_in_item = t_in_item'(s_axis_tdata[$bits(t_in_item)-1:0]);

    uecho_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_item   (w_in_item),
        .o_out_valid (w_q_valid),
        .i_out_ready (w_q_ready),
        .o_out_item  (w_q_item)
    );

    uecho_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_ticks  (r_bit_ticks),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_item   (w_out_item)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_out_item)){1'b0}}, w_out_item};

endmodule

FILE: design/uecho_queue.sv
// Front end of the UART echo unit: two-entry queue of unpacked tick items.
// Depends on uecho_pkg.
module uecho_queue import uecho_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_in_item o_out_item
);

    t_in_item               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [PTR_W-1:0]       n_wr_ptr;
    logic [PTR_W-1:0]       n_rd_ptr;
    logic [CNT_W-1:0]       n_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_in_ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_mem[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_item;
        end
    end

endmodule

FILE: design/uecho_core.sv
// Back end of the UART echo unit, depends on uecho_pkg: transmitter, receiver,
// echo and output registers. One tick item per cycle unless the output stalls.
module uecho_core import uecho_pkg::*; #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TICK_W-1:0] i_bit_ticks,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  t_in_item          i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    localparam logic [BYTE_W-1:0] DATA_MASK   = BYTE_W'((9'd1 << DATA_BITS) - 9'd1);
    localparam logic [IDX_W-1:0]  DATA_IDX    = IDX_W'(DATA_BITS);
    localparam logic [IDX_W-1:0]  TX_LAST_IDX = IDX_W'(DATA_BITS + 1);
    localparam int unsigned       MSB_POS     = DATA_BITS - 1;

    // transmitter
    logic [BYTE_W-1:0]     r_tx_shift,  n_tx_shift;
    logic [IDX_W-1:0]      r_tx_idx,    n_tx_idx;
    logic [TICK_W-1:0]     r_tx_timer,  n_tx_timer;
    logic                  r_tx_busy,   n_tx_busy;
    logic                  r_tx_line,   n_tx_line;
    // receiver
    logic [BYTE_W-1:0]     r_rx_shift,  n_rx_shift;
    logic [IDX_W-1:0]      r_rx_idx,    n_rx_idx;
    logic [RX_TIMER_W-1:0] r_rx_timer,  n_rx_timer;
    t_rx_phase             r_rx_phase,  n_rx_phase;
    // echo
    logic                  r_echo_flag,    n_echo_flag;
    logic                  r_echo_pending, n_echo_pending;
    logic [BYTE_W-1:0]     r_echo_byte,    n_echo_byte;
    // output register
    logic                  r_out_valid;
    t_out_item             r_out_item,  n_out_item;

    logic                  w_fire;
    logic [TICK_W-1:0]     w_period;
    logic [TICK_W-1:0]     w_reload;
    logic [RX_TIMER_W-1:0] w_first_wait;
    logic [RX_TIMER_W-1:0] w_rx_dec;
    logic [IDX_W-1:0]      w_rx_idx_inc;
    logic [IDX_W-1:0]      w_tx_idx_inc;
    logic [BYTE_W-1:0]     w_byte;
    logic                  w_got;
    logic                  w_take_echo;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign w_fire       = i_item_valid && o_item_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out_item;

    // a period of zero counts as one
    assign w_period     = (i_bit_ticks == '0) ? TICK_W'(1) : i_bit_ticks;
    assign w_reload     = w_period - TICK_W'(1);
    assign w_first_wait = {1'b0, w_period} + RX_TIMER_W'(w_period >> 1);
    assign w_rx_dec     = r_rx_timer - RX_TIMER_W'(1);
    assign w_rx_idx_inc = r_rx_idx + IDX_W'(1);
    assign w_tx_idx_inc = r_tx_idx + IDX_W'(1);
    assign w_byte       = r_rx_shift & DATA_MASK;

    // transmitter acts first, on the state at the start of the tick
    always_comb begin
        n_tx_shift  = r_tx_shift;
        n_tx_idx    = r_tx_idx;
        n_tx_timer  = r_tx_timer;
        n_tx_busy   = r_tx_busy;
        n_tx_line   = r_tx_line;
        w_take_echo = 1'b0;
        if (!r_tx_busy) begin
            if (r_echo_pending || i_item.tx_valid) begin
                w_take_echo = r_echo_pending;
                n_tx_shift  = (r_echo_pending ? r_echo_byte : i_item.tx_data) & DATA_MASK;
                n_tx_idx    = '0;
                n_tx_timer  = w_reload;
                n_tx_busy   = 1'b1;
                n_tx_line   = 1'b0;
            end
        end else if (r_tx_timer != '0) begin
            n_tx_timer = r_tx_timer - TICK_W'(1);
        end else begin
            n_tx_idx   = w_tx_idx_inc;
            n_tx_timer = w_reload;
            if (w_tx_idx_inc <= DATA_IDX) begin
                n_tx_line  = r_tx_shift[0];
                n_tx_shift = r_tx_shift >> 1;
            end else begin
                n_tx_line  = 1'b1;
            end
        end
        // end of the stop bit
        if (n_tx_busy && (n_tx_idx == TX_LAST_IDX) && (n_tx_timer == '0)) begin
            n_tx_busy = 1'b0;
            n_tx_idx  = '0;
            n_tx_line = 1'b1;
        end
    end

    // receiver phase, next state
    always_comb begin
        n_rx_phase = r_rx_phase;
        unique case (r_rx_phase)
            RX_DATA: begin
                if ((w_rx_dec == '0) && (w_rx_idx_inc >= DATA_IDX)) begin
                    n_rx_phase = RX_STOP;
                end
            end
            RX_STOP: begin
                if (w_rx_dec == '0) begin
                    n_rx_phase = RX_HUNT;
                end
            end
            default: begin
                n_rx_phase = i_item.rx_level ? RX_HUNT : RX_DATA;
            end
        endcase
    end

    // receiver datapath and echo control
    always_comb begin
        n_rx_shift = r_rx_shift;
        n_rx_idx   = r_rx_idx;
        n_rx_timer = r_rx_timer;
        w_got      = 1'b0;
        unique case (r_rx_phase)
            RX_DATA: begin
                n_rx_timer = w_rx_dec;
                if (w_rx_dec == '0) begin
                    n_rx_shift = ((r_rx_shift >> 1) | ({{(BYTE_W - 1){1'b0}}, i_item.rx_level}
                                  << MSB_POS)) & DATA_MASK;
                    n_rx_idx   = w_rx_idx_inc;
                    n_rx_timer = {1'b0, w_period};
                end
            end
            RX_STOP: begin
                n_rx_timer = w_rx_dec;
                w_got      = (w_rx_dec == '0);
            end
            default: begin
                if (!i_item.rx_level) begin
                    n_rx_shift = '0;
                    n_rx_idx   = '0;
                    n_rx_timer = w_first_wait;
                end
            end
        endcase

        n_echo_pending = w_take_echo ? 1'b0 : r_echo_pending;
        n_echo_byte    = r_echo_byte;
        n_echo_flag    = r_echo_flag;
        if (w_got) begin
            // queue the byte only if echo was on before it arrived
            if (r_echo_flag) begin
                n_echo_byte    = w_byte;
                n_echo_pending = 1'b1;
            end
            if (w_byte == ECHO_ON_CODE) begin
                n_echo_flag = 1'b1;
            end
            if (w_byte == ECHO_OFF_CODE) begin
                n_echo_flag = 1'b0;
            end
        end

        n_out_item.tx_level = n_tx_line;
        n_out_item.tx_ready = !n_tx_busy && !n_echo_pending;
        n_out_item.rx_valid = w_got;
        n_out_item.rx_data  = w_got ? w_byte : '0;
        n_out_item.echo_on  = n_echo_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift     <= '0;
            r_tx_idx       <= '0;
            r_tx_timer     <= '0;
            r_tx_busy      <= 1'b0;
            r_tx_line      <= 1'b1;
            r_rx_shift     <= '0;
            r_rx_idx       <= '0;
            r_rx_timer     <= '0;
            r_rx_phase     <= RX_HUNT;
            r_echo_flag    <= 1'b0;
            r_echo_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tx_shift     <= n_tx_shift;
                r_tx_idx       <= n_tx_idx;
                r_tx_timer     <= n_tx_timer;
                r_tx_busy      <= n_tx_busy;
                r_tx_line      <= n_tx_line;
                r_rx_shift     <= n_rx_shift;
                r_rx_idx       <= n_rx_idx;
                r_rx_timer     <= n_rx_timer;
                r_rx_phase     <= n_rx_phase;
                r_echo_flag    <= n_echo_flag;
                r_echo_pending <= n_echo_pending;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_echo_byte <= n_echo_byte;
            r_out_item  <= n_out_item;
        end
    end

endmodule

FILE: design/uecho_checker.sv
// Port-level checker for the UART echo unit, bound to the top level.
// Depends on uecho_pkg and uart_8n1_transceiver_echo_unit_defines.svh.
`include "uart_8n1_transceiver_echo_unit_defines.svh"

module uecho_checker import uecho_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   pready
);

    t_out_item w_out;

    assign w_out = t_out_item'(m_axis_tdata[$bits(t_out_item)-1:0]);

    `UECHO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output transfer changed")
    `UECHO_ASSERT_SAME(a_rx_data_zero, m_axis_tvalid && !w_out.rx_valid, w_out.rx_data == '0, "rx_data nonzero without rx_valid")
    `UECHO_ASSERT_SAME(a_idle_line_high, m_axis_tvalid && w_out.tx_ready, w_out.tx_level, "transmit line low while transmitter ready")
    `UECHO_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind uart_8n1_transceiver_echo_unit uecho_checker u_checker (.*);

FILE: verif/uart_8n1_transceiver_echo_unit_tb.sv
// Self-checking testbench for the UART 8N1 transceiver with echo mode.
// Drives one tick per stream transfer and compares every output tick against a local line model.
// Depends on uecho_pkg and the RTL of uart_8n1_transceiver_echo_unit.
`timescale 1ns / 100ps

module uart_8n1_transceiver_echo_unit_tb;
    import uecho_pkg::*;

    localparam int NBITS       = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [BYTE_W-1:0] DATA_MASK = BYTE_W'((1 << NBITS) - 1);

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    wire  [APB_DATA_W-1:0]  prdata;
    wire                    pready;

    uart_8n1_transceiver_echo_unit #(
        .DATA_BITS(NBITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Line model state, at its reset values
    logic [TICK_W-1:0]     bit_ticks_q  = BIT_TICKS_RESET;
    logic [BYTE_W-1:0]     tx_sr        = '0;
    logic [IDX_W-1:0]      tx_bits      = '0;
    logic [TICK_W-1:0]     tx_wait      = '0;
    logic                  tx_active    = 1'b0;
    logic                  tx_pin       = 1'b1;
    logic [BYTE_W-1:0]     rx_sr        = '0;
    logic [IDX_W-1:0]      rx_bits      = '0;
    logic [RX_TIMER_W-1:0] rx_wait      = '0;
    t_rx_phase             rx_state     = RX_HUNT;
    logic                  echo_mode    = 1'b0;
    logic                  echo_queued  = 1'b0;
    logic [BYTE_W-1:0]     echo_held    = '0;

    t_in_item  tick_q[$];
    t_out_item tick_result_q[$];

    logic [31:0] ticks_sent     = '0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          src_gap        = 0;
    int          sink_gap       = 0;
    int          sink_hold_left = 0;
    logic        sink_hold_done = 1'b0;
    int          cycles         = 0;

    // no new random idles start on either side while this is high
    wire calm = (ticks_sent[9:8] == 2'b00);

    // Advance the line model by one tick and return the outputs after it.
    task automatic uart_tick_predict(input t_in_item it, output t_out_item res);
        logic [TICK_W-1:0] per;
        logic [BYTE_W-1:0] load_v;
        logic              do_load;
        logic [BYTE_W-1:0] rx_code;
        logic              rx_got;
        per     = (bit_ticks_q == '0) ? TICK_W'(1) : bit_ticks_q;
        do_load = 1'b0;
        load_v  = '0;
        rx_code = '0;
        rx_got  = 1'b0;

        // transmitter acts first, on the state from the start of the tick
        if (!tx_active) begin
            if (echo_queued) begin
                echo_queued = 1'b0;
                do_load     = 1'b1;
                load_v      = echo_held;
            end else if (it.tx_valid) begin
                do_load = 1'b1;
                load_v  = it.tx_data;
            end
            if (do_load) begin
                tx_sr     = load_v & DATA_MASK;
                tx_bits   = '0;
                tx_wait   = per - 1'b1;
                tx_active = 1'b1;
                tx_pin    = 1'b0;
            end
        end else if (tx_wait != '0) begin
            tx_wait = tx_wait - 1'b1;
        end else begin
            tx_bits = tx_bits + 1'b1;
            tx_wait = per - 1'b1;
            if (tx_bits <= NBITS) begin
                tx_pin = tx_sr[0];
                tx_sr  = tx_sr >> 1;
            end else begin
                tx_pin = 1'b1;
            end
        end
        if (tx_active && tx_bits == NBITS + 1 && tx_wait == '0) begin
            tx_active = 1'b0;
            tx_bits   = '0;
            tx_pin    = 1'b1;
        end

        case (rx_state)
            RX_DATA: begin
                rx_wait = rx_wait - 1'b1;
                if (rx_wait == '0) begin
                    rx_sr   = ((rx_sr >> 1) | (BYTE_W'(it.rx_level) << (NBITS - 1))) & DATA_MASK;
                    rx_bits = rx_bits + 1'b1;
                    rx_wait = RX_TIMER_W'(per);
                    if (rx_bits >= NBITS) rx_state = RX_STOP;
                end
            end
            RX_STOP: begin
                rx_wait = rx_wait - 1'b1;
                if (rx_wait == '0) begin
                    rx_state = RX_HUNT;
                    rx_code  = rx_sr & DATA_MASK;
                    rx_got   = 1'b1;
                    // echo decision uses the mode from before this byte
                    if (echo_mode) begin
                        echo_held   = rx_code;
                        echo_queued = 1'b1;
                    end
                    if (rx_code == ECHO_ON_CODE)  echo_mode = 1'b1;
                    if (rx_code == ECHO_OFF_CODE) echo_mode = 1'b0;
                end
            end
            default: begin
                rx_state = RX_HUNT;
                if (!it.rx_level) begin
                    rx_state = RX_DATA;
                    rx_sr    = '0;
                    rx_bits  = '0;
                    rx_wait  = RX_TIMER_W'((3 * int'(per)) / 2);
                end
            end
        endcase

        res.tx_level = tx_pin;
        res.tx_ready = !tx_active && !echo_queued;
        res.rx_valid = rx_got;
        res.rx_data  = rx_got ? rx_code : '0;
        res.echo_on  = echo_mode;
    endtask

    function automatic int draw_idle();
        return ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 3))
                                            : int'($urandom_range(10, 40));
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at output tick %0d: expected %0h, got %0h",
                     what, results_seen, want, got);
    endtask

    task automatic add_tick(input logic level, input int req_pct, input logic force_req);
        t_in_item it;
        it.rx_level = level;
        it.tx_valid = force_req || ($urandom_range(0, 99) < req_pct);
        it.tx_data  = BYTE_W'($urandom);
        tick_q.push_back(it);
    endtask

    task automatic add_request(input logic [BYTE_W-1:0] data_v);
        t_in_item it;
        it.rx_level = 1'b1;
        it.tx_valid = 1'b1;
        it.tx_data  = data_v;
        tick_q.push_back(it);
    endtask

    // Line-level frame: start bit, data bits LSB first, stop bit, then idle high.
    task automatic add_frame(input logic [BYTE_W-1:0] code, input int p, input int stop_len,
                             input int idle_len, input int req_pct, input int req_tick);
        int   n;
        logic lvl;
        for (n = 0; n < (NBITS + 1) * p + stop_len + idle_len; n++) begin
            if (n < p)                    lvl = 1'b0;
            else if (n < (NBITS + 1) * p) lvl = code[(n - p) / p];
            else                          lvl = 1'b1;
            add_tick(lvl, req_pct, n == req_tick);
        end
    endtask

    task automatic run_random_phase(input int p, input int n_ticks);
        int                r;
        int                k;
        int                bits;
        logic              lvl;
        logic [BYTE_W-1:0] code;
        while (tick_q.size() < n_ticks) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                k = $urandom_range(0, 99);
                code = (k < 15) ? ECHO_ON_CODE :
                       (k < 30) ? ECHO_OFF_CODE :
                       (k < 36) ? 8'h00 :
                       (k < 42) ? 8'hFF : BYTE_W'($urandom);
                k = $urandom_range(0, 99);
                add_frame(code, p, $urandom_range(p / 2 + 1, p),
                          (k < 55) ? 0 : (k < 90) ? $urandom_range(1, p)
                                                  : $urandom_range(p, 12 * p),
                          $urandom_range(0, 20), -1);
            end else if (r < 88) begin
                // ragged or cut-off frame: bit lengths off by a tick, random levels
                bits = $urandom_range(1, NBITS + 2);
                for (k = 0; k < bits; k++) begin
                    lvl = (k == 0) ? 1'b0 : 1'($urandom);
                    repeat ($urandom_range(p - 1, p + 1)) add_tick(lvl, 10, 1'b0);
                end
                repeat ($urandom_range(1, 2 * p)) add_tick(1'b1, 10, 1'b0);
            end else begin
                repeat ($urandom_range(1, 2 * p)) add_tick(1'($urandom), 10, 1'b0);
            end
        end
        // let the receiver finish before the period changes
        repeat (12 * p) add_tick(1'b1, 10, 1'b0);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || s_axis_tvalid || tick_result_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bit_ticks(input logic [TICK_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_BIT_TICKS, 2'b00};
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bit_ticks_q = v;
    endtask

    // Input side: one tick per transfer, predicted when it is accepted.
    always @(posedge i_clk) begin : source
        t_in_item  taken;
        t_in_item  nxt;
        t_out_item predicted;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken = s_axis_tdata[$bits(t_in_item)-1:0];
                uart_tick_predict(taken, predicted);
                tick_result_q.push_back(predicted);
                ticks_sent <= ticks_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    nxt = tick_q.pop_front();
                    s_axis_tdata  <= {{(IN_TDATA_W - $bits(t_in_item)){1'b0}}, nxt};
                    s_axis_tvalid <= 1'b1;
                    src_gap       <= (!calm && $urandom_range(0, 99) < 35) ? draw_idle() : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the output side once for a long stretch so the input side backs up.
    always @(posedge i_clk) begin : sink_hold
        if (!i_rst_n) begin
            sink_hold_left <= 0;
        end else if (!sink_hold_done && ticks_sent >= 1000) begin
            sink_hold_left <= 400;
            sink_hold_done <= 1'b1;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    // Output side: compare each transfer with the oldest predicted tick.
    always @(posedge i_clk) begin : sink
        t_out_item seen;
        t_out_item want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[$bits(t_out_item)-1:0];
                if (tick_result_q.size() == 0) begin
                    note_mismatch("transfer with no tick pending", 0, seen);
                end else begin
                    want = tick_result_q.pop_front();
                    if (seen.tx_level !== want.tx_level)
                        note_mismatch("tx_level", want.tx_level, seen.tx_level);
                    if (seen.tx_ready !== want.tx_ready)
                        note_mismatch("tx_ready", want.tx_ready, seen.tx_ready);
                    if (seen.rx_valid !== want.rx_valid)
                        note_mismatch("rx_valid", want.rx_valid, seen.rx_valid);
                    if (seen.rx_data !== want.rx_data)
                        note_mismatch("rx_data", want.rx_data, seen.rx_data);
                    if (seen.echo_on !== want.echo_on)
                        note_mismatch("echo_on", want.echo_on, seen.echo_on);
                end
                results_seen++;
            end
            if (sink_hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                m_axis_tready <= 1'b0;
                sink_gap      <= sink_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) sink_gap <= draw_idle();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int dir_p;
        int phase_p[4];
        int i;
        dir_p   = 5;
        phase_p = '{4, 8, 6, 5};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset period, idle line: outputs must show the reset state
        repeat (16) add_tick(1'b1, 0, 1'b0);
        wait_drained();

        write_bit_ticks(TICK_W'(dir_p));
        add_request(8'h00);
        repeat (12 * dir_p) add_tick(1'b1, 0, 1'b0);
        // send and receive at once with echo off, then turn echo on: only the last byte is echoed
        add_request(8'hFF);
        add_frame(8'h00, dir_p, dir_p, 8, 0, -1);
        add_frame(ECHO_ON_CODE, dir_p, dir_p, 2, 0, -1);
        add_frame(8'hFF, dir_p, dir_p, 11 * dir_p, 0, -1);
        // turning echo on while on: the code itself is echoed
        add_frame(ECHO_ON_CODE, dir_p, dir_p, 11 * dir_p, 0, -1);
        // request loads one tick before delivery, so the next echo byte overwrites the held one
        add_frame(8'h3C, dir_p, dir_p / 2 + 1, 0, 0, (3 * dir_p) / 2 + NBITS * dir_p - 1);
        add_frame(8'hC3, dir_p, dir_p / 2 + 1, 11 * dir_p, 0, -1);
        // off code is echoed, then echo stops
        add_frame(ECHO_OFF_CODE, dir_p, dir_p, 11 * dir_p, 0, -1);
        add_frame(ECHO_OFF_CODE, dir_p, dir_p, 4, 0, -1);
        // one-tick glitch starts a frame anyway
        add_tick(1'b0, 0, 1'b0);
        repeat (12 * dir_p) add_tick(1'b1, 0, 1'b0);
        wait_drained();

        for (i = 0; i < 4; i++) begin
            write_bit_ticks(TICK_W'(phase_p[i]));
            run_random_phase(phase_p[i], 165);
            wait_drained();
        end

        // longest period: frames start on both sides but never finish
        write_bit_ticks(16'hFFFF);
        repeat (10) add_tick(1'b1, 0, 1'b0);
        add_request(8'hA5);
        repeat (12) add_tick(1'b0, 0, 1'b0);
        repeat (100) add_tick(1'b1, 30, 1'b0);
        wait_drained();

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
